// ----- rtl/jsu_pkg.sv -----
`default_nettype none

package jsu_pkg;

    // Default depth of the request queue between the front and back halves
    localparam int JSU_QUEUE_DEPTH = 4;

    // Characters the decoder recognizes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_DIG0   = 8'h30;
    localparam logic [7:0] CH_DIG9   = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;

    // Control bytes produced by the short escapes
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_TAB = 8'h09;

    // Top six bits of a UTF-16 unit for the two surrogate ranges
    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

    // Offset added to a surrogate pair's 20 payload bits
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_HEX1,
        MODE_NEEDBS,
        MODE_NEEDU,
        MODE_HEX2
    } decode_mode_t;

    typedef enum logic [1:0] {
        CMD_RAW,
        CMD_CP,
        CMD_ERR
    } cmd_kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } jsu_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       error;
        logic       string_end;
    } jsu_out_t;

    // One request from the decoder to the UTF-8 emitter
    typedef struct packed {
        cmd_kind_t   kind;
        logic [20:0] value;
        logic        str_last;
    } jsu_cmd_t;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= CH_DIG0 && c <= CH_DIG9) begin
            r = {1'b1, 4'(c - CH_DIG0)};
        end else if (c >= CH_LA && c <= CH_LF) begin
            r = {1'b1, 4'(c - CH_LA + 8'd10)};
        end else if (c >= CH_UA && c <= CH_UF) begin
            r = {1'b1, 4'(c - CH_UA + 8'd10)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/jsu_front.sv -----
`default_nettype none

module jsu_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  jsu_pkg::jsu_in_t      s_data,
    output logic                  push_valid,
    input  wire logic             push_ready,
    output jsu_pkg::jsu_cmd_t     push_cmd
);
    import jsu_pkg::*;

    decode_mode_t mode_reg, mode_next, mode_step;
    logic [1:0]   count_reg, count_next, count_step;
    logic [15:0]  high_reg, high_next, high_step;
    logic [15:0]  low_reg, low_next, low_step;
    logic         drain_reg, drain_next;

    logic         accept;
    logic [7:0]   c;
    logic         last;
    logic [4:0]   hex;
    logic [15:0]  high_shift;
    logic [15:0]  low_shift;
    logic         step_fault;
    logic         step_emit;
    cmd_kind_t    step_kind;
    logic [20:0]  step_value;
    logic         fault;

    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;
    assign c       = s_data.in_byte;
    assign last    = s_data.in_last;

    // Classify the byte against the current escape state
    always_comb begin
        hex        = hex_nibble(c);
        high_shift = {high_reg[11:0], hex[3:0]};
        low_shift  = {low_reg[11:0], hex[3:0]};
        step_fault = 1'b0;
        step_emit  = 1'b0;
        step_kind  = CMD_RAW;
        step_value = '0;
        mode_step  = mode_reg;
        count_step = count_reg;
        high_step  = high_reg;
        low_step   = low_reg;
        unique case (mode_reg)
            MODE_ESC: begin
                mode_step = MODE_NORMAL;
                step_emit = 1'b1;
                priority if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH) begin
                    step_value = {13'd0, c};
                end else if (c == CH_B) begin
                    step_value = {13'd0, BYTE_BS};
                end else if (c == CH_F) begin
                    step_value = {13'd0, BYTE_FF};
                end else if (c == CH_N) begin
                    step_value = {13'd0, BYTE_LF};
                end else if (c == CH_R) begin
                    step_value = {13'd0, BYTE_CR};
                end else if (c == CH_T) begin
                    step_value = {13'd0, BYTE_TAB};
                end else if (c == CH_U) begin
                    step_emit  = 1'b0;
                    mode_step  = MODE_HEX1;
                    count_step = 2'd0;
                    high_step  = '0;
                end else begin
                    step_emit  = 1'b0;
                    step_fault = 1'b1;
                end
            end
            MODE_HEX1: begin
                if (!hex[4]) begin
                    step_fault = 1'b1;
                end else begin
                    high_step = high_shift;
                    if (count_reg != 2'd3) begin
                        count_step = count_reg + 2'd1;
                    end else begin
                        count_step = 2'd0;
                        priority if (high_shift[15:10] == SURR_LOW_TAG) begin
                            step_fault = 1'b1;
                        end else if (high_shift[15:10] == SURR_HIGH_TAG) begin
                            mode_step = MODE_NEEDBS;
                        end else begin
                            mode_step  = MODE_NORMAL;
                            step_emit  = 1'b1;
                            step_kind  = CMD_CP;
                            step_value = {5'd0, high_shift};
                        end
                    end
                end
            end
            MODE_NEEDBS: begin
                if (c == CH_BSLASH) begin
                    mode_step = MODE_NEEDU;
                end else begin
                    step_fault = 1'b1;
                end
            end
            MODE_NEEDU: begin
                if (c == CH_U) begin
                    mode_step  = MODE_HEX2;
                    count_step = 2'd0;
                    low_step   = '0;
                end else begin
                    step_fault = 1'b1;
                end
            end
            MODE_HEX2: begin
                if (!hex[4]) begin
                    step_fault = 1'b1;
                end else begin
                    low_step = low_shift;
                    if (count_reg != 2'd3) begin
                        count_step = count_reg + 2'd1;
                    end else begin
                        count_step = 2'd0;
                        if (low_shift[15:10] != SURR_LOW_TAG) begin
                            step_fault = 1'b1;
                        end else begin
                            mode_step  = MODE_NORMAL;
                            step_emit  = 1'b1;
                            step_kind  = CMD_CP;
                            step_value = SUPP_BASE
                                       + {1'b0, high_reg[9:0], low_shift[9:0]};
                        end
                    end
                end
            end
            default: begin
                mode_step = MODE_NORMAL;
                if (c == CH_BSLASH) begin
                    mode_step = MODE_ESC;
                end else begin
                    step_emit  = 1'b1;
                    step_value = {13'd0, c};
                end
            end
        endcase
        // End of string inside an escape or after a high surrogate
        fault = step_fault || (last && mode_step != MODE_NORMAL);
    end

    // Next state: clear at string end or fault, drain after a fault
    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        drain_next = drain_reg;
        if (accept) begin
            if (drain_reg) begin
                if (last) begin
                    drain_next = 1'b0;
                end
            end else if (fault || last) begin
                mode_next  = MODE_NORMAL;
                count_next = 2'd0;
                high_next  = '0;
                low_next   = '0;
                drain_next = fault && !last;
            end else begin
                mode_next  = mode_step;
                count_next = count_step;
                high_next  = high_step;
                low_next   = low_step;
            end
        end
    end

    // Outputs: one request per byte that yields a result
    always_comb begin
        push_valid        = accept && !drain_reg && (fault || step_emit);
        push_cmd.kind     = fault ? CMD_ERR : step_kind;
        push_cmd.value    = fault ? '0 : step_value;
        push_cmd.str_last = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_NORMAL;
            count_reg <= 2'd0;
            high_reg  <= '0;
            low_reg   <= '0;
            drain_reg <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
            drain_reg <= drain_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/jsu_queue.sv -----
`default_nettype none

module jsu_queue #(
    parameter int DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  jsu_pkg::jsu_cmd_t  push_cmd,
    output logic               pop_valid,
    input  wire logic          pop,
    output jsu_pkg::jsu_cmd_t  pop_cmd
);
    import jsu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_cmd_t        slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Advance pointers with wrap, track occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/jsu_back.sv -----
`default_nettype none

module jsu_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_pop,
    input  jsu_pkg::jsu_cmd_t  q_cmd,
    output logic               m_valid,
    input  wire logic          m_ready,
    output jsu_pkg::jsu_out_t  m_data
);
    import jsu_pkg::*;

    logic [1:0]  idx_reg, idx_next;
    logic        m_valid_reg, m_valid_next;
    jsu_out_t    m_data_reg, m_data_next;

    logic [1:0]  len_m1;
    logic [7:0]  cur_byte;
    logic [20:0] cp;
    logic        final_byte;
    logic        load;

    assign cp = q_cmd.value;

    // Pick the UTF-8 byte at the current index of the head request
    always_comb begin
        len_m1   = 2'd0;
        cur_byte = 8'h00;
        unique case (q_cmd.kind)
            CMD_RAW: begin
                cur_byte = cp[7:0];
            end
            CMD_CP: begin
                priority if (cp < 21'h80) begin
                    cur_byte = cp[7:0];
                end else if (cp < 21'h800) begin
                    len_m1   = 2'd1;
                    cur_byte = (idx_reg == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
                end else if (cp < 21'h10000) begin
                    len_m1 = 2'd2;
                    unique case (idx_reg)
                        2'd0:    cur_byte = {4'b1110, cp[15:12]};
                        2'd1:    cur_byte = {2'b10, cp[11:6]};
                        default: cur_byte = {2'b10, cp[5:0]};
                    endcase
                end else begin
                    len_m1 = 2'd3;
                    unique case (idx_reg)
                        2'd0:    cur_byte = {5'b11110, cp[20:18]};
                        2'd1:    cur_byte = {2'b10, cp[17:12]};
                        2'd2:    cur_byte = {2'b10, cp[11:6]};
                        default: cur_byte = {2'b10, cp[5:0]};
                    endcase
                end
            end
            default: begin
                cur_byte = 8'h00;
            end
        endcase
    end

    assign final_byte = (idx_reg == len_m1);
    assign load       = q_valid && (!m_valid_reg || m_ready);
    assign q_pop      = load && final_byte;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    // Fill the output register whenever it is empty or being drained
    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next           = 1'b1;
            m_data_next.out_byte   = cur_byte;
            m_data_next.run_last   = final_byte;
            m_data_next.error      = (q_cmd.kind == CMD_ERR);
            m_data_next.string_end = final_byte && q_cmd.str_last;
            idx_next               = final_byte ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/json_string_unescape_to_utf8.sv -----
// A byte's first result passes through the request queue and then the output register;
// the UTF-8 emitter sends one result byte per cycle while m_ready is high, so a code
// point's further UTF-8 bytes follow one per cycle. Input takes one byte per cycle while
// the QUEUE_DEPTH-entry request queue, which absorbs multi-byte expansions, has room.
// Reset: synchronous, active low; clears the decoder state, the queue and the output valid.
`default_nettype none

module json_string_unescape_to_utf8 #(
    parameter int QUEUE_DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  jsu_pkg::jsu_in_t   s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output jsu_pkg::jsu_out_t  m_data
);
    import jsu_pkg::*;

    logic      push_valid;
    logic      push_ready;
    jsu_cmd_t  push_cmd;
    logic      q_valid;
    logic      q_pop;
    jsu_cmd_t  q_cmd;

    // Decode escapes and surrogates into emit requests
    jsu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Hold requests between decoder and emitter
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    // Serialize each request into UTF-8 bytes
    jsu_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_cmd   (q_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // An error result stands alone and carries a zero byte
    a_err_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error |-> m_data.run_last && (m_data.out_byte == 8'h00))
        else $error("error result not alone or nonzero");

    // String end only on the last result of a byte
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.string_end |-> m_data.run_last)
        else $error("string_end without run_last");

    // A lead byte that opens a UTF-8 sequence is never followed by an error result
    a_no_lead_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.error && (m_data.out_byte[7:6] == 2'b11)
        && !m_data.run_last |=> !(m_valid && m_data.error))
        else $error("error inside a UTF-8 sequence");

    // Output is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

// ----- tb/json_string_unescape_to_utf8_test.sv -----
module json_string_unescape_to_utf8_test;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int TOTAL_BYTES    = 230;
    localparam int PRESSURE_AT    = 150;
    localparam int PRESSURE_HOLD  = 120;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CYCLE_LIMIT    = 200000;

    localparam logic [7:0] SHORT_ESC [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                            CH_F, CH_N, CH_R, CH_T};

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    jsu_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    jsu_out_t m_data;

    // Requests waiting to be offered, and the string under construction
    jsu_in_t    pending_reqs [$];
    logic [7:0] text_buf [$];

    // Decoded bytes still owed by the block, oldest first
    jsu_out_t expected_bytes [$];
    jsu_out_t head_byte;

    // Decoder state mirrored from the block's behavior
    decode_mode_t esc_mode     = MODE_NORMAL;
    logic [1:0]   digits_seen  = '0;
    logic [15:0]  first_unit   = '0;
    logic [15:0]  second_unit  = '0;
    logic         draining     = 1'b0;

    int  mismatches     = 0;
    int  accepted_count = 0;
    int  cycle_count    = 0;
    int  send_wait      = 0;
    int  hold_left      = 0;
    int  src_calm       = 0;
    int  sink_calm      = 0;
    bit  pressure_done  = 1'b0;
    bit  s_fire         = 1'b0;

    json_string_unescape_to_utf8 dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Value of a hex digit, or -1 for any other byte
    function automatic int hex_val(input logic [7:0] c);
        if (c >= CH_DIG0 && c <= CH_DIG9) return int'(c - CH_DIG0);
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        return -1;
    endfunction

    // Split a code point into its UTF-8 byte sequence
    function automatic int utf8_encode(input logic [20:0] cp, output logic [7:0] seq [4]);
        seq = '{default: 8'h00};
        if (cp < 21'h80) begin
            seq[0] = cp[7:0];
            return 1;
        end
        if (cp < 21'h800) begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
            return 2;
        end
        if (cp < 21'h10000) begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
            return 3;
        end
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
        return 4;
    endfunction

    function automatic void clear_decoder();
        esc_mode    = MODE_NORMAL;
        digits_seen = '0;
        first_unit  = '0;
        second_unit = '0;
        draining    = 1'b0;
    endfunction

    // Advance the decoder by one byte and queue the bytes it yields
    function automatic void unescape_byte(input logic [7:0] c, input logic fin);
        logic [7:0]  seq [4];
        logic [20:0] cp;
        jsu_out_t    r;
        int          n;
        int          d;
        logic        bad;
        n   = 0;
        bad = 1'b0;
        seq = '{default: 8'h00};
        if (draining) begin
            if (fin) clear_decoder();
            return;
        end
        case (esc_mode)
            MODE_ESC: begin
                esc_mode = MODE_NORMAL;
                case (c)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: begin seq[0] = c;        n = 1; end
                    CH_B:                          begin seq[0] = BYTE_BS;  n = 1; end
                    CH_F:                          begin seq[0] = BYTE_FF;  n = 1; end
                    CH_N:                          begin seq[0] = BYTE_LF;  n = 1; end
                    CH_R:                          begin seq[0] = BYTE_CR;  n = 1; end
                    CH_T:                          begin seq[0] = BYTE_TAB; n = 1; end
                    CH_U: begin
                        esc_mode    = MODE_HEX1;
                        digits_seen = '0;
                        first_unit  = '0;
                    end
                    default: bad = 1'b1;
                endcase
            end
            MODE_HEX1: begin
                d = hex_val(c);
                if (d < 0) begin
                    bad = 1'b1;
                end else begin
                    first_unit = {first_unit[11:0], 4'(d)};
                    if (digits_seen != 2'd3) begin
                        digits_seen++;
                    end else begin
                        digits_seen = '0;
                        if (first_unit >= 16'hDC00 && first_unit <= 16'hDFFF) begin
                            bad = 1'b1;
                        end else if (first_unit >= 16'hD800 && first_unit <= 16'hDBFF) begin
                            esc_mode = MODE_NEEDBS;
                        end else begin
                            esc_mode = MODE_NORMAL;
                            n = utf8_encode({5'd0, first_unit}, seq);
                        end
                    end
                end
            end
            MODE_NEEDBS: begin
                if (c == CH_BSLASH) esc_mode = MODE_NEEDU;
                else bad = 1'b1;
            end
            MODE_NEEDU: begin
                if (c == CH_U) begin
                    esc_mode    = MODE_HEX2;
                    digits_seen = '0;
                    second_unit = '0;
                end else begin
                    bad = 1'b1;
                end
            end
            MODE_HEX2: begin
                d = hex_val(c);
                if (d < 0) begin
                    bad = 1'b1;
                end else begin
                    second_unit = {second_unit[11:0], 4'(d)};
                    if (digits_seen != 2'd3) begin
                        digits_seen++;
                    end else begin
                        digits_seen = '0;
                        if (second_unit < 16'hDC00 || second_unit > 16'hDFFF) begin
                            bad = 1'b1;
                        end else begin
                            esc_mode = MODE_NORMAL;
                            cp = 21'h10000 + {1'b0, first_unit[9:0], second_unit[9:0]};
                            n = utf8_encode(cp, seq);
                        end
                    end
                end
            end
            default: begin
                esc_mode = MODE_NORMAL;
                if (c == CH_BSLASH) begin
                    esc_mode = MODE_ESC;
                end else begin
                    seq[0] = c;
                    n = 1;
                end
            end
        endcase

        // A string may not end inside an escape or after a high surrogate
        if (!bad && fin && esc_mode != MODE_NORMAL) bad = 1'b1;

        if (bad) begin
            r.out_byte   = 8'h00;
            r.run_last   = 1'b1;
            r.error      = 1'b1;
            r.string_end = fin;
            expected_bytes.insert(expected_bytes.size(), r);
            clear_decoder();
            draining = !fin;
            return;
        end
        for (int k = 0; k < n; k++) begin
            r.out_byte   = seq[k];
            r.run_last   = (k == n - 1);
            r.error      = 1'b0;
            r.string_end = fin && (k == n - 1);
            expected_bytes.insert(expected_bytes.size(), r);
        end
        if (fin) clear_decoder();
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Idle length: mostly none or short, now and then long, with calm stretches
    function automatic int next_gap(inout int calm);
        int pick;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            calm = $urandom_range(20, 50);
            return 0;
        end
        if (pick < 55) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Append one byte to the string under construction
    task automatic add_byte(input logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    // Append a backslash-u escape carrying the top digit_cnt hex digits of unit
    task automatic add_escape_u(input logic [15:0] unit, input int digit_cnt);
        logic [3:0] nib;
        add_byte(CH_BSLASH);
        add_byte(CH_U);
        for (int i = 3; i > 3 - digit_cnt; i--) begin
            nib = unit[i*4 +: 4];
            if (nib < 4'd10) add_byte(CH_DIG0 + 8'(nib));
            else add_byte(($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(nib - 4'd10));
        end
    endtask

    // Turn the string under construction into requests, flagging its final byte
    task automatic end_string();
        jsu_in_t req;
        while (text_buf.size() != 0) begin
            req.in_byte = text_buf.pop_front();
            req.in_last = (text_buf.size() == 0);
            pending_reqs.insert(pending_reqs.size(), req);
        end
    endtask

    // Offer requests, holding each until accepted, with random gaps after it
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (send_wait > 0) begin
                s_valid   <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (pending_reqs.size() != 0) begin
                s_data    <= pending_reqs.pop_front();
                s_valid   <= 1'b1;
                send_wait <= next_gap(src_calm);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random, once for a long stretch mid-run
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!pressure_done && accepted_count >= PRESSURE_AT) begin
            m_ready       <= 1'b0;
            hold_left     <= PRESSURE_HOLD;
            pressure_done <= 1'b1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) hold_left <= next_gap(sink_calm);
        end
    end

    // Predict on accepted requests, check every accepted result
    always @(posedge aclk) begin
        s_fire <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            accepted_count <= accepted_count + 1;
            unescape_byte(s_data.in_byte, s_data.in_last);
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                $error("result with none expected: out_byte %0h error %0b",
                       m_data.out_byte, m_data.error);
                mismatches++;
            end else begin
                head_byte = expected_bytes.pop_front();
                check_field("out_byte", head_byte.out_byte, m_data.out_byte);
                check_field("run_last", 8'(head_byte.run_last), 8'(m_data.run_last));
                check_field("error", 8'(head_byte.error), 8'(m_data.error));
                check_field("string_end", 8'(head_byte.string_end), 8'(m_data.string_end));
            end
        end
    end

    // Give up on a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int          total_items;
        int          segs;
        int          pick;
        bit          cut;
        logic [7:0]  b;
        logic [15:0] unit;
        logic [15:0] high;

        // Directed strings: byte extremes, a few escapes, code point zero,
        // the largest surrogate pair, and several kinds of format fault
        add_byte(8'h00);
        add_byte(8'hFF);
        end_string();
        add_text("\\t\\/");
        end_string();
        add_escape_u(16'h0000, 4);
        end_string();
        add_escape_u(16'hDBFF, 4);
        add_escape_u(16'hDFFF, 4);
        end_string();
        add_text("\\qz");
        end_string();
        add_escape_u(16'hDC00, 4);
        end_string();
        add_escape_u(16'hD800, 4);
        end_string();
        add_text("\\");
        end_string();
        add_text("\\u0G");
        end_string();

        // Random strings: mostly well formed, some broken, some raw noise
        while (pending_reqs.size() < TOTAL_BYTES) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 10)) begin
                    if ($urandom_range(0, 3) == 0) add_byte(CH_BSLASH);
                    else add_byte(8'($urandom_range(0, 255)));
                end
            end else begin
                segs = $urandom_range(1, 6);
                cut  = 1'b0;
                for (int k = 0; k < segs && !cut; k++) begin
                    pick = $urandom_range(0, 99);
                    high = 16'hD800 | 16'($urandom_range(0, 'h3FF));
                    if (pick < 40) begin
                        b = 8'($urandom_range(0, 255));
                        if (b == CH_BSLASH) add_byte(CH_BSLASH);
                        add_byte(b);
                    end else if (pick < 60) begin
                        add_byte(CH_BSLASH);
                        add_byte(SHORT_ESC[$urandom_range(0, 7)]);
                    end else if (pick < 80) begin
                        case ($urandom_range(0, 2))
                            0:       unit = 16'($urandom_range(0, 'h7F));
                            1:       unit = 16'($urandom_range('h80, 'h7FF));
                            default: unit = 16'($urandom_range('h800, 'hFFFF));
                        endcase
                        // move surrogate values out of the surrogate block
                        if (unit[15:11] == 5'b11011) unit[14] = ~unit[14];
                        add_escape_u(unit, 4);
                    end else if (pick < 92) begin
                        add_escape_u(high, 4);
                        add_escape_u(16'hDC00 | 16'($urandom_range(0, 'h3FF)), 4);
                    end else begin
                        case ($urandom_range(0, 6))
                            0: begin
                                do b = 8'($urandom_range(0, 255));
                                while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                                 CH_F, CH_N, CH_R, CH_T, CH_U});
                                add_byte(CH_BSLASH);
                                add_byte(b);
                            end
                            1: begin
                                add_escape_u(16'($urandom), $urandom_range(0, 3));
                                do b = 8'($urandom_range(0, 255));
                                while (hex_val(b) >= 0);
                                add_byte(b);
                            end
                            2: add_escape_u(16'hDC00 | 16'($urandom_range(0, 'h3FF)), 4);
                            3: begin
                                b = 8'($urandom_range(0, 255));
                                if (b == CH_BSLASH) b = CH_QUOTE;
                                add_escape_u(high, 4);
                                add_byte(b);
                            end
                            4: begin
                                b = 8'($urandom_range(0, 255));
                                if (b == CH_U) b = CH_N;
                                add_escape_u(high, 4);
                                add_byte(CH_BSLASH);
                                add_byte(b);
                            end
                            5: begin
                                unit = 16'($urandom);
                                if (unit[15:10] == 6'b110111) unit[10] = 1'b0;
                                add_escape_u(high, 4);
                                add_escape_u(unit, 4);
                            end
                            default: begin
                                // end the string in the middle of an escape
                                cut = 1'b1;
                                case ($urandom_range(0, 4))
                                    0: add_byte(CH_BSLASH);
                                    1: add_escape_u(16'($urandom), $urandom_range(0, 3));
                                    2: add_escape_u(high, 4);
                                    3: begin
                                        add_escape_u(high, 4);
                                        add_byte(CH_BSLASH);
                                    end
                                    default: begin
                                        add_escape_u(high, 4);
                                        add_escape_u(16'($urandom), $urandom_range(0, 3));
                                    end
                                endcase
                            end
                        endcase
                    end
                end
            end
            end_string();
        end
        total_items = pending_reqs.size();

        // Release reset at a falling edge
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every request to go in and every decoded byte to come out
        @(posedge aclk);
        while (accepted_count < total_items || expected_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
